### src/fra_pkg.sv
package fra_pkg;

  localparam logic [2:0] ACT_MOV = 3'd0;
  localparam logic [2:0] ACT_ADD = 3'd1;
  localparam logic [2:0] ACT_SUB = 3'd2;
  localparam logic [2:0] ACT_MUL = 3'd3;
  localparam logic [2:0] ACT_DIV = 3'd4;
  localparam logic [2:0] ACT_HLT = 3'd5;

  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_BAD_DEST = 2'd1;
  localparam logic [1:0] ST_DIV_ZERO = 2'd2;
  localparam logic [1:0] ST_IGNORED  = 2'd3;

  localparam logic [1:0] K_ADD = 2'd0;
  localparam logic [1:0] K_SUB = 2'd1;
  localparam logic [1:0] K_MUL = 2'd2;
  localparam logic [1:0] K_DIV = 2'd3;

  typedef struct packed {
    logic       start;
    logic [1:0] kind;
  } fra_cmd_t;

endpackage

### src/fra_serial.sv
module fra_serial import fra_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fra_cmd_t              cmd,
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] result
);

  localparam int CW = $clog2(DATA_WIDTH);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_ITER = 2'd1;
  localparam logic [1:0] U_FIX  = 2'd2;

  logic [1:0]            state;
  logic [CW-1:0]         cnt;
  logic [1:0]            kind;
  logic [DATA_WIDTH-1:0] x;
  logic [DATA_WIDTH-1:0] y;
  logic [DATA_WIDTH-1:0] acc;
  logic                  carry;
  logic                  neg;

  logic                  sum_bit;
  logic                  carry_next;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;

  // one bit per cycle through the sum / multiplier / quotient shift registers
  assign sum_bit    = x[0] ^ y[0] ^ carry;
  assign carry_next = (x[0] & y[0]) | (x[0] & carry) | (y[0] & carry);
  assign rem_sh     = {acc, x[DATA_WIDTH-1]};
  assign diff       = rem_sh - {1'b0, y};
  assign result     = (kind == K_MUL) ? acc : x;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == U_FIX);
      case (state)
        U_IDLE: begin
          if (cmd.start) begin
            state <= U_ITER;
          end
        end
        U_ITER: begin
          if (cnt == '0) begin
            state <= U_FIX;
          end
        end
        U_FIX: begin
          state <= U_IDLE;
        end
        default: begin
          state <= U_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      U_IDLE: begin
        if (cmd.start) begin
          kind <= cmd.kind;
          cnt  <= CW'(DATA_WIDTH - 1);
          acc  <= '0;
          neg  <= a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1];
          case (cmd.kind)
            K_ADD: begin
              x     <= a;
              y     <= b;
              carry <= 1'b0;
            end
            K_SUB: begin
              x     <= a;
              y     <= ~b;
              carry <= 1'b1;
            end
            K_MUL: begin
              x     <= a;
              y     <= b;
              carry <= 1'b0;
            end
            default: begin
              // magnitudes, sign fixed up at the end
              x     <= a[DATA_WIDTH-1] ? (~a + 1'b1) : a;
              y     <= b[DATA_WIDTH-1] ? (~b + 1'b1) : b;
              carry <= 1'b0;
            end
          endcase
        end
      end
      U_ITER: begin
        cnt <= cnt - 1'b1;
        case (kind)
          K_ADD, K_SUB: begin
            x     <= {sum_bit, x[DATA_WIDTH-1:1]};
            y     <= {1'b0, y[DATA_WIDTH-1:1]};
            carry <= carry_next;
          end
          K_MUL: begin
            if (y[0]) begin
              acc <= acc + x;
            end
            x <= {x[DATA_WIDTH-2:0], 1'b0};
            y <= {1'b0, y[DATA_WIDTH-1:1]};
          end
          default: begin
            if (!diff[DATA_WIDTH]) begin
              acc <= diff[DATA_WIDTH-1:0];
              x   <= {x[DATA_WIDTH-2:0], 1'b1};
            end else begin
              acc <= rem_sh[DATA_WIDTH-1:0];
              x   <= {x[DATA_WIDTH-2:0], 1'b0};
            end
          end
        endcase
      end
      U_FIX: begin
        if (kind == K_DIV && neg) begin
          x <= ~x + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  a_done_after_fix: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == U_FIX)
    else $error("done without a fix-up cycle");

  a_iter_counts: assert property (@(posedge clk) disable iff (rst)
    (state == U_ITER && cnt != '0) |=> (state == U_ITER && cnt == $past(cnt) - 1'b1))
    else $error("iteration count broken");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> state == U_IDLE)
    else $error("start while serial unit busy");

endmodule

### src/four_register_alu_executor.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  action, dest_is_register, dest_reg,
//                                          src_is_register, src_reg, immediate
// out      output     out_valid / out_stall status, halted, reg_ax .. reg_dx
//
// halt, no-op, rejected and ignored items: accept, S_PUT, then the output register
// move and zero divisor: S_OPA, S_OPB, S_EXEC, S_PUT; add, subtract, multiply, divide
// also pass S_RUN, serial unit: one bit of sum, multiplier or quotient per cycle
// synchronous reset clears all four registers, the halt flag and out_valid
// a stalled result waits in the output register; the next item is taken
// the cycle after the result has moved into that register
module four_register_alu_executor import fra_pkg::*; #(
  parameter int DATA_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         action,
  input  logic               dest_is_register,
  input  logic [1:0]         dest_reg,
  input  logic               src_is_register,
  input  logic [1:0]         src_reg,
  input  logic signed [15:0] immediate,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic               halted,
  output logic signed [15:0] reg_ax,
  output logic signed [15:0] reg_bx,
  output logic signed [15:0] reg_cx,
  output logic signed [15:0] reg_dx
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OPA  = 3'd1;
  localparam logic [2:0] S_OPB  = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_RUN  = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;

  logic [2:0]            state;
  logic [DATA_WIDTH-1:0] regs [4];
  logic                  halt_flag;
  logic [2:0]            act;
  logic [1:0]            dst;
  logic                  src_isr;
  logic [1:0]            src;
  logic [DATA_WIDTH-1:0] imm_ext;
  logic [DATA_WIDTH-1:0] opa;
  logic [DATA_WIDTH-1:0] opb;
  logic [1:0]            st;

  logic [1:0]            rd_sel;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [DATA_WIDTH+15:0] imm_wide;
  logic [DATA_WIDTH+15:0] ax_wide;
  logic [DATA_WIDTH+15:0] bx_wide;
  logic [DATA_WIDTH+15:0] cx_wide;
  logic [DATA_WIDTH+15:0] dx_wide;
  logic                  in_take;
  logic                  out_free;
  fra_cmd_t              ucmd;
  logic                  udone;
  logic [DATA_WIDTH-1:0] uresult;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign imm_wide = {{DATA_WIDTH{immediate[15]}}, immediate};
  assign ax_wide  = {16'b0, regs[0]};
  assign bx_wide  = {16'b0, regs[1]};
  assign cx_wide  = {16'b0, regs[2]};
  assign dx_wide  = {16'b0, regs[3]};

  // one register file read port, dest first then source
  assign rd_sel  = (state == S_OPA) ? dst : src;
  assign rd_data = regs[rd_sel];

  always_comb begin
    ucmd.start = 1'b0;
    ucmd.kind  = K_ADD;
    if (state == S_EXEC) begin
      case (act)
        ACT_ADD: begin
          ucmd.start = 1'b1;
          ucmd.kind  = K_ADD;
        end
        ACT_SUB: begin
          ucmd.start = 1'b1;
          ucmd.kind  = K_SUB;
        end
        ACT_MUL: begin
          ucmd.start = 1'b1;
          ucmd.kind  = K_MUL;
        end
        ACT_DIV: begin
          ucmd.start = (opb != '0);
          ucmd.kind  = K_DIV;
        end
        default: begin
          ucmd.start = 1'b0;
        end
      endcase
    end
  end

  fra_serial #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_serial (
    .clk    (clk),
    .rst    (rst),
    .cmd    (ucmd),
    .a      (opa),
    .b      (opb),
    .done   (udone),
    .result (uresult)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      halt_flag <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        regs[i] <= '0;
      end
    end else begin
      if (state == S_PUT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            act     <= action;
            dst     <= dest_reg;
            src_isr <= src_is_register;
            src     <= src_reg;
            imm_ext <= imm_wide[DATA_WIDTH-1:0];
            if (halt_flag) begin
              st    <= ST_IGNORED;
              state <= S_PUT;
            end else if (action == ACT_HLT) begin
              st        <= ST_DONE;
              halt_flag <= 1'b1;
              state     <= S_PUT;
            end else if (action > ACT_DIV) begin
              st    <= ST_DONE;
              state <= S_PUT;
            end else if (!dest_is_register) begin
              st    <= ST_BAD_DEST;
              state <= S_PUT;
            end else begin
              st    <= ST_DONE;
              state <= S_OPA;
            end
          end
        end
        S_OPA: begin
          opa   <= rd_data;
          state <= S_OPB;
        end
        S_OPB: begin
          opb   <= src_isr ? rd_data : imm_ext;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (act == ACT_MOV) begin
            regs[dst] <= opb;
            state     <= S_PUT;
          end else if (act == ACT_DIV && opb == '0) begin
            st    <= ST_DIV_ZERO;
            state <= S_PUT;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (udone) begin
            regs[dst] <= uresult;
            state     <= S_PUT;
          end
        end
        S_PUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (state == S_PUT && out_free) begin
      status <= st;
      halted <= halt_flag;
      reg_ax <= ax_wide[15:0];
      reg_bx <= bx_wide[15:0];
      reg_cx <= cx_wide[15:0];
      reg_dx <= dx_wide[15:0];
    end
  end

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    udone |-> state == S_RUN)
    else $error("serial result outside run state");

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(halt_flag))
    else $error("halt flag cleared without reset");

  a_ignored_halted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_IGNORED) |-> halted)
    else $error("ignored item reported while not halted");

endmodule
